// ===== rtl/bffa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

	// field widths
	localparam int ADDR_W   = 48;
	localparam int BYTES_W  = 32;
	localparam int USED_W   = 21;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 48;

	// operation codes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STS_FAIL     = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NOTFOUND = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b1;

	// configuration reset values
	localparam logic [ADDR_W-1:0]  BASE_RESET  = 48'd0;
	localparam logic [BYTES_W-1:0] TOTAL_RESET = 32'd1048576;

	// controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_MARK,
		S_RESP
	} bffa_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic clear_en;
		logic scan_init;
		logic scan_en;
		logic mark_en;
		logic resp_load;
	} bffa_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clear_done;
		logic need_bad;
		logic scan_hit;
		logic scan_miss;
		logic mark_done;
	} bffa_sts_t;

endpackage

// ===== rtl/bffa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bffa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer of the allocator: clearing pass, size check, scan, mark, response.
// ----------------------------------------------------------------------------
module bffa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	output logic                out_valid,
	input  logic                out_stall,
	input  bffa_pkg::bffa_sts_t sts,
	output bffa_pkg::bffa_cmd_t cmd
);
	import bffa_pkg::*;

	bffa_state_t state_q;
	bffa_state_t state_d;
	logic        out_valid_q;
	logic        accept;
	logic        resp_load;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign resp_load = (state_q == S_RESP) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) state_d = (operation == OP_RELEASE) ? S_SCAN : S_CHECK;
			end
			S_CHECK: begin
				state_d = sts.need_bad ? S_RESP : S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_hit) state_d = S_MARK;
				else if (sts.scan_miss) state_d = S_RESP;
			end
			S_MARK: begin
				if (sts.mark_done) state_d = S_RESP;
			end
			S_RESP: begin
				if (resp_load) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// command outputs
	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.resp_load = resp_load;
		case (state_q)
			S_CLEAR: cmd.clear_en = 1'b1;
			S_IDLE:  cmd.scan_init = accept && (operation == OP_RELEASE);
			S_CHECK: cmd.scan_init = !sts.need_bad;
			S_SCAN:  cmd.scan_en = 1'b1;
			S_MARK:  cmd.mark_en = 1'b1;
			default: cmd.accept = accept;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// an accepted transaction always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted transaction did not start work");

	// a finished result waits while the previous one is stalled
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_valid_q && out_stall) |=> (state_q == S_RESP))
		else $error("result overwritten while output stalled");

	// a stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("result dropped while output stalled");

endmodule

// ===== rtl/bffa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_datapath
// Block map RAM, size check, first-fit scan, run marking and result regs.
// ----------------------------------------------------------------------------
module bffa_datapath #(
	parameter int NUM_BLOCKS  = 1024,
	parameter int BLOCK_BYTES = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [bffa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bffa_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               operation,
	input  logic [bffa_pkg::BYTES_W-1:0]       request_bytes,
	input  logic [bffa_pkg::ADDR_W-1:0]        release_address,
	input  bffa_pkg::bffa_cmd_t                cmd,
	output bffa_pkg::bffa_sts_t                sts,
	output logic [bffa_pkg::STATUS_W-1:0]      status,
	output logic [bffa_pkg::ADDR_W-1:0]        granted_address,
	output logic [bffa_pkg::USED_W-1:0]        used_bytes,
	output logic [bffa_pkg::BYTES_W-1:0]       free_bytes
);
	import bffa_pkg::*;

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int LW = $clog2(NUM_BLOCKS + 1);
	localparam int EW = LW + 1;
	localparam longint unsigned POOL_BYTES = longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);
	localparam int UW = $clog2(POOL_BYTES + 1);
	localparam int CW = (UW > BYTES_W) ? UW : BYTES_W;

	localparam logic [ADDR_W-1:0] BB_A    = ADDR_W'(BLOCK_BYTES);
	localparam logic [UW-1:0]     BB_U    = UW'(BLOCK_BYTES);
	localparam logic [CW-1:0]     POOL_C  = CW'(POOL_BYTES);
	localparam logic [IW-1:0]     LAST_I  = IW'(NUM_BLOCKS - 1);
	localparam logic [IW:0]       N_I     = (IW + 1)'(NUM_BLOCKS);

	// configuration
	logic [ADDR_W-1:0]  base_q;
	logic [BYTES_W-1:0] total_q;

	// transaction
	logic               op_q;
	logic [ADDR_W-1:0]  rel_addr_q;
	logic [BYTES_W-1:0] req_q;

	// clearing pass
	logic [IW-1:0]      clr_idx_q;

	// scan
	logic [IW:0]        rd_idx_q;
	logic               rd_pend_q;
	logic [IW-1:0]      ev_idx_q;
	logic [ADDR_W-1:0]  addr_acc_q;
	logic [LW-1:0]      run_q;
	logic [UW-1:0]      run_bytes_q;
	logic [IW-1:0]      run_start_idx_q;
	logic [ADDR_W-1:0]  run_start_addr_q;
	logic [LW-1:0]      run_next;
	logic [UW-1:0]      run_bytes_next;
	logic               ent_res;
	logic [LW-1:0]      ent_len;
	logic               hit;
	logic               miss;
	logic               hit_q;
	logic [ADDR_W-1:0]  grant_addr_q;

	// marking
	logic [IW-1:0]      mark_idx_q;
	logic [LW-1:0]      mark_cnt_q;
	logic               mark_first_q;
	logic [UW-1:0]      used_q;

	// ram ports
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [EW-1:0]      ram_wdata;
	logic               ram_re;
	logic [EW-1:0]      ram_rdata;

	// result registers
	logic [STATUS_W-1:0] out_status_q;
	logic [ADDR_W-1:0]   out_grant_q;
	logic [USED_W-1:0]   out_used_q;
	logic [BYTES_W-1:0]  out_free_q;

	// reservation bit and run length per block
	bffa_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_BLOCKS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RESET;
			total_q <= TOTAL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data[ADDR_W-1:0];
				CFG_TOTAL: total_q <= cfg_data[BYTES_W-1:0];
				default:   base_q  <= base_q;
			endcase
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= operation;
			rel_addr_q <= release_address;
			req_q      <= request_bytes;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear_en) begin
			clr_idx_q <= clr_idx_q + IW'(1);
		end
	end

	// scan evaluation of the entry read in the previous cycle
	assign ent_res        = ram_rdata[EW-1];
	assign ent_len        = ram_rdata[LW-1:0];
	assign run_next       = ent_res ? '0 : (run_q + LW'(1));
	assign run_bytes_next = ent_res ? '0 : (run_bytes_q + BB_U);

	// alloc hits when the free run covers the request; release on a matching run
	always_comb begin
		hit = 1'b0;
		if (cmd.scan_en && rd_pend_q) begin
			if (op_q == OP_ALLOC) begin
				hit = !ent_res && (CW'(run_bytes_next) >= CW'(req_q));
			end else begin
				hit = (ent_len != '0) && (addr_acc_q == rel_addr_q);
			end
		end
	end
	assign miss = cmd.scan_en && rd_pend_q && !hit && (ev_idx_q == LAST_I);
	assign ram_re = cmd.scan_en && (rd_idx_q < N_I);

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_pend_q <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.accept || cmd.scan_init) begin
			rd_idx_q  <= '0;
			rd_pend_q <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.scan_en) begin
			rd_pend_q <= ram_re;
			if (ram_re) rd_idx_q <= rd_idx_q + (IW + 1)'(1);
			if (hit) hit_q <= 1'b1;
		end
	end

	// scan payload: address, current free run and hit capture
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			addr_acc_q  <= base_q;
			run_q       <= '0;
			run_bytes_q <= '0;
		end else if (cmd.scan_en) begin
			ev_idx_q <= rd_idx_q[IW-1:0];
			if (rd_pend_q) begin
				addr_acc_q  <= addr_acc_q + BB_A;
				run_q       <= run_next;
				run_bytes_q <= run_bytes_next;
				if (!ent_res && run_q == '0) begin
					run_start_idx_q  <= ev_idx_q;
					run_start_addr_q <= addr_acc_q;
				end
				if (hit) begin
					mark_first_q <= 1'b1;
					if (op_q == OP_ALLOC) begin
						mark_idx_q   <= (run_q == '0) ? ev_idx_q : run_start_idx_q;
						grant_addr_q <= (run_q == '0) ? addr_acc_q : run_start_addr_q;
						mark_cnt_q   <= run_next;
					end else begin
						mark_idx_q <= ev_idx_q;
						mark_cnt_q <= ent_len;
					end
				end
			end
		end else if (cmd.mark_en) begin
			mark_idx_q   <= mark_idx_q + IW'(1);
			mark_cnt_q   <= mark_cnt_q - LW'(1);
			mark_first_q <= 1'b0;
		end
	end

	// reserved byte count follows each marked or released block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.mark_en) begin
			used_q <= (op_q == OP_ALLOC) ? (used_q + BB_U) : (used_q - BB_U);
		end
	end

	// ram write: clearing pass or run marking, run length at the start block
	always_comb begin
		ram_we    = cmd.clear_en || cmd.mark_en;
		ram_waddr = cmd.clear_en ? clr_idx_q : mark_idx_q;
		ram_wdata = '0;
		if (cmd.mark_en && op_q == OP_ALLOC) begin
			ram_wdata = {1'b1, (mark_first_q ? mark_cnt_q : LW'(0))};
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			if (hit_q) out_status_q <= STS_DONE;
			else if (op_q == OP_RELEASE) out_status_q <= STS_NOTFOUND;
			else out_status_q <= STS_FAIL;
			out_grant_q <= (hit_q && op_q == OP_ALLOC) ? grant_addr_q : '0;
			out_used_q  <= USED_W'(used_q);
			out_free_q  <= (CW'(total_q) > CW'(used_q)) ?
				BYTES_W'(CW'(total_q) - CW'(used_q)) : '0;
		end
	end

	assign status          = out_status_q;
	assign granted_address = out_grant_q;
	assign used_bytes      = out_used_q;
	assign free_bytes      = out_free_q;

	// status to the controller
	always_comb begin
		sts            = '0;
		sts.clear_done = cmd.clear_en && (clr_idx_q == LAST_I);
		sts.need_bad   = (req_q == '0) || (CW'(req_q) > POOL_C);
		sts.scan_hit   = hit;
		sts.scan_miss  = miss;
		sts.mark_done  = cmd.mark_en && (mark_cnt_q == LW'(1));
	end

	// a scan step never reports both outcomes
	a_hit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit && miss))
		else $error("scan hit and miss together");

	// every marking cycle has a block left to write
	a_mark_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_en |-> (mark_cnt_q != '0))
		else $error("marking with empty run count");

	// reserved bytes stay within the pool
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(POOL_BYTES))
		else $error("reserved byte count beyond pool size");

endmodule

// ===== rtl/bitmap_first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_core
// First-fit allocator over a pool of equal blocks with one map entry per block.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid/in_stall): operation, request_bytes and
//    release_address form one transaction; taken when in_valid is high and
//    in_stall is low. in_stall is high while a transaction is in work.
//  - output channel (out_valid/out_stall): status, granted_address,
//    used_bytes and free_bytes, one result per transaction, held in an
//    output register until taken.
//  - configuration: cfg_write with cfg_index 0 sets the pool base address,
//    index 1 the total pool bytes; write only while no transaction is open.
//  - allocate: accept, size check, map scan (one RAM read a cycle), marking
//    of the run one block at a time, then a load into the output register
//    once it is free. release: accept, map scan, clearing of the run one
//    block at a time, then the output register load. One transaction at a
//    time; the map scan goes over the single read port.
//  - reset: after arst_n is released a clearing pass writes every map entry,
//    during which in_stall stays high.
//  - a stalled receiver holds the result; a finished next result waits in
//    the controller until the output register is free.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator_core #(
	parameter int NUM_BLOCKS  = 1024,
	parameter int BLOCK_BYTES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [bffa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bffa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [bffa_pkg::BYTES_W-1:0]    request_bytes,
	input  logic [bffa_pkg::ADDR_W-1:0]     release_address,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bffa_pkg::STATUS_W-1:0]   status,
	output logic [bffa_pkg::ADDR_W-1:0]     granted_address,
	output logic [bffa_pkg::USED_W-1:0]     used_bytes,
	output logic [bffa_pkg::BYTES_W-1:0]    free_bytes
);
	import bffa_pkg::*;

	bffa_cmd_t cmd;
	bffa_sts_t sts;

	// sequencer
	bffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// map, size check, scan and result registers
	bffa_datapath #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.request_bytes   (request_bytes),
		.release_address (release_address),
		.cmd             (cmd),
		.sts             (sts),
		.status          (status),
		.granted_address (granted_address),
		.used_bytes      (used_bytes),
		.free_bytes      (free_bytes)
	);

endmodule

// ===== tb/bitmap_first_fit_block_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_core_tb
// Self-checking bench for the first-fit block allocator. A short table of
// allocate and release requests runs after reset, followed by random
// requests under several pool base and size settings. Every result is
// compared field by field with the table's expected reply or with a behavioral
// model of the block map that the bench keeps in step with the accepted transactions.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator_core_tb;
	import bffa_pkg::*;

	localparam int BLK_COUNT       = 1024;
	localparam int BLK_BYTES       = 1024;
	localparam int ITEMS_PER_PHASE = 93;
	localparam int PHASES          = 6;
	localparam int PLAN_ROWS       = 22;
	localparam int SETTLE_CYCLES   = 2 * BLK_COUNT + 64;
	localparam int CYCLE_LIMIT     = 8_000_000;

	typedef struct packed {
		logic [STATUS_W-1:0] sts;
		logic [ADDR_W-1:0]   addr;
		logic [USED_W-1:0]   used;
		logic [BYTES_W-1:0]  free;
	} reply_t;

	typedef struct packed {
		logic               op;
		logic [BYTES_W-1:0] nbytes;
		logic [ADDR_W-1:0]  rel_addr;
		logic               typed;
		reply_t             want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  operation;
	logic [BYTES_W-1:0]    request_bytes;
	logic [ADDR_W-1:0]     release_address;
	logic                  out_valid;
	logic                  out_stall;
	logic [STATUS_W-1:0]   status;
	logic [ADDR_W-1:0]     granted_address;
	logic [USED_W-1:0]     used_bytes;
	logic [BYTES_W-1:0]    free_bytes;

	// model of the allocator state
	bit                blk_taken [BLK_COUNT];
	int unsigned       run_at [BLK_COUNT];
	longint unsigned   bytes_held;
	logic [ADDR_W-1:0] pool_base;
	logic [BYTES_W-1:0] pool_total;

	reply_t      replies_due [$];
	plan_row_t   plan [PLAN_ROWS];
	int          fault_cnt;
	int unsigned cycle_cnt;
	int          snd_idle_pct;
	int          rcv_idle_pct;

	bitmap_first_fit_block_allocator_core #(
		.NUM_BLOCKS(BLK_COUNT),
		.BLOCK_BYTES(BLK_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.request_bytes(request_bytes),
		.release_address(release_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.granted_address(granted_address),
		.used_bytes(used_bytes),
		.free_bytes(free_bytes)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run time guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("status: fail");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
	end

	task automatic report_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display("%0t ns mismatch: %s", $time, msg);
	endtask

	// first-fit allocate or release on the model; returns the expected reply
	function automatic reply_t apply_request(input logic op, input logic [BYTES_W-1:0] nbytes,
			input logic [ADDR_W-1:0] rel_addr);
		reply_t            r;
		longint unsigned   need;
		int unsigned       run;
		int unsigned       first;
		int unsigned       len;
		logic [ADDR_W-1:0] blk_addr;
		bit                done;
		r = '0;
		done = 1'b0;
		if (op == OP_ALLOC) begin
			r.sts = STS_FAIL;
			need = ({32'd0, nbytes} + BLK_BYTES - 1) / BLK_BYTES;
			run = 0;
			if (need != 0 && need <= BLK_COUNT) begin
				for (int i = 0; i < BLK_COUNT && !done; i++) begin
					if (blk_taken[i])
						run = 0;
					else
						run++;
					if (run == need) begin
						first = i + 1 - run;
						for (int k = first; k <= i; k++)
							blk_taken[k] = 1'b1;
						run_at[first] = run;
						bytes_held += longint'(run) * BLK_BYTES;
						r.addr = pool_base + ADDR_W'(first * BLK_BYTES);
						r.sts = STS_DONE;
						done = 1'b1;
					end
				end
			end
		end else begin
			r.sts = STS_NOTFOUND;
			for (int i = 0; i < BLK_COUNT && !done; i++) begin
				len = run_at[i];
				blk_addr = pool_base + ADDR_W'(i * BLK_BYTES);
				if (len != 0 && blk_addr == rel_addr) begin
					for (int k = 0; k < len && i + k < BLK_COUNT; k++) begin
						blk_taken[i + k] = 1'b0;
						if (bytes_held >= BLK_BYTES)
							bytes_held -= BLK_BYTES;
						else
							bytes_held = 0;
					end
					run_at[i] = 0;
					r.sts = STS_DONE;
					done = 1'b1;
				end
			end
		end
		r.used = bytes_held[USED_W-1:0];
		r.free = ({32'd0, pool_total} > bytes_held) ? pool_total - bytes_held[31:0] : '0;
		return r;
	endfunction

	// one request transaction; called and returning at a falling edge
	task automatic send_request(input logic op, input logic [BYTES_W-1:0] nbytes,
			input logic [ADDR_W-1:0] rel_addr, input bit drain_first, input bit typed,
			input reply_t want);
		reply_t model;
		if (drain_first || $urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk);
			while ((drain_first && replies_due.size() != 0) ||
				$urandom_range(0, 99) < snd_idle_pct);
		end
		operation       <= op;
		request_bytes   <= nbytes;
		release_address <= rel_addr;
		in_valid        <= 1'b1;
		do @(posedge clk);
		while (in_stall);
		model = apply_request(op, nbytes, rel_addr);
		replies_due.push_back(typed ? want : model);
		@(negedge clk);
	endtask

	// write both pool registers while the block is idle
	task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [BYTES_W-1:0] total);
		cfg_write <= 1'b1;
		cfg_index <= CFG_BASE;
		cfg_data  <= base;
		@(negedge clk);
		cfg_index <= CFG_TOTAL;
		cfg_data  <= {{(CFG_DATA_W-BYTES_W){1'b0}}, total};
		@(negedge clk);
		cfg_write <= 1'b0;
		pool_base  = base;
		pool_total = total;
	endtask

	// wait until every outstanding result has been taken
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk);
		while (replies_due.size() != 0);
	endtask

	// random request, weighted toward releases when the pool is crowded
	task automatic pick_request(output logic op, output logic [BYTES_W-1:0] nbytes,
			output logic [ADDR_W-1:0] rel_addr);
		int live [$];
		int sel;
		op = ($urandom_range(0, 99) < (bytes_held > 64'd700000 ? 70 : 40)) ?
			OP_RELEASE : OP_ALLOC;
		sel = $urandom_range(0, 99);
		nbytes = $urandom;
		rel_addr = {16'($urandom), 32'($urandom)};
		if (op == OP_ALLOC) begin
			if (sel < 55)
				nbytes = $urandom_range(1, 8 * BLK_BYTES);
			else if (sel < 70)
				nbytes = $urandom_range(1, 64 * BLK_BYTES);
			else if (sel < 78)
				nbytes = $urandom_range(1, 16) * BLK_BYTES + $urandom_range(0, 1);
			else if (sel < 83)
				nbytes = '0;
			else if (sel < 91)
				nbytes = $urandom_range(1, (BLK_COUNT + 2) * BLK_BYTES);
		end else begin
			for (int i = 0; i < BLK_COUNT; i++)
				if (run_at[i] != 0)
					live.push_back(i);
			if (live.size() != 0 && sel < 70)
				rel_addr = pool_base +
					ADDR_W'(live[$urandom_range(0, live.size() - 1)] * BLK_BYTES);
			else if (sel < 85)
				rel_addr = pool_base + ADDR_W'($urandom_range(0, BLK_COUNT - 1) * BLK_BYTES) +
					ADDR_W'($urandom_range(0, 1));
		end
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		reply_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				report_fault("result with nothing outstanding");
			end else begin
				due = replies_due.pop_front();
				if (status !== due.sts)
					report_fault($sformatf("sts exp %0d got %0d", due.sts, status));
				if (granted_address !== due.addr)
					report_fault($sformatf("granted_address exp %h got %h",
						due.addr, granted_address));
				if (used_bytes !== due.used)
					report_fault($sformatf("used_bytes exp %0d got %0d", due.used, used_bytes));
				if (free_bytes !== due.free)
					report_fault($sformatf("free_bytes exp %0d got %0d", due.free, free_bytes));
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic               op;
		logic [BYTES_W-1:0] nbytes;
		logic [ADDR_W-1:0]  rel_addr;
		logic [ADDR_W-1:0]  phase_base [PHASES];
		logic [BYTES_W-1:0] phase_total [PHASES];

		arst_n          = 1'b0;
		cfg_write       = 1'b0;
		cfg_index       = CFG_BASE;
		cfg_data        = '0;
		in_valid        = 1'b0;
		operation       = OP_ALLOC;
		request_bytes   = '0;
		release_address = '0;
		out_stall       = 1'b0;
		fault_cnt       = 0;
		cycle_cnt       = 0;
		snd_idle_pct    = 35;
		rcv_idle_pct    = 73;
		bytes_held      = 0;
		pool_base       = BASE_RESET;
		pool_total      = TOTAL_RESET;
		for (int i = 0; i < BLK_COUNT; i++) begin
			blk_taken[i] = 1'b0;
			run_at[i]    = 0;
		end

		// allocate and release corners from reset; last rows go to the model only
		plan = '{
			'{OP_ALLOC,   32'd0,          48'd0,    1'b1, '{STS_FAIL,     48'd0,    21'd0,       32'd1048576}},
			'{OP_ALLOC,   32'd1,          48'd0,    1'b1, '{STS_DONE,     48'd0,    21'd1024,    32'd1047552}},
			'{OP_ALLOC,   32'd1024,       48'd0,    1'b1, '{STS_DONE,     48'd1024, 21'd2048,    32'd1046528}},
			'{OP_ALLOC,   32'd1025,       48'd0,    1'b1, '{STS_DONE,     48'd2048, 21'd4096,    32'd1044480}},
			'{OP_RELEASE, 32'd0,          48'd1024, 1'b1, '{STS_DONE,     48'd0,    21'd3072,    32'd1045504}},
			'{OP_RELEASE, 32'd0,          48'd1024, 1'b1, '{STS_NOTFOUND, 48'd0,    21'd3072,    32'd1045504}},
			'{OP_RELEASE, 32'd0,          48'd1,    1'b1, '{STS_NOTFOUND, 48'd0,    21'd3072,    32'd1045504}},
			'{OP_ALLOC,   32'hFFFF_FFFF,  48'd0,    1'b1, '{STS_FAIL,     48'd0,    21'd3072,    32'd1045504}},
			'{OP_ALLOC,   32'd1048577,    48'd0,    1'b1, '{STS_FAIL,     48'd0,    21'd3072,    32'd1045504}},
			'{OP_ALLOC,   32'd512,        48'd0,    1'b1, '{STS_DONE,     48'd1024, 21'd4096,    32'd1044480}},
			'{OP_RELEASE, 32'hFFFF_FFFF,  48'hFFFF_FFFF_FFFF,
				1'b1, '{STS_NOTFOUND, 48'd0, 21'd4096, 32'd1044480}},
			'{OP_RELEASE, 32'd0,          48'd0,    1'b1, '{STS_DONE,     48'd0,    21'd3072,    32'd1045504}},
			'{OP_RELEASE, 32'd0,          48'd1024, 1'b1, '{STS_DONE,     48'd0,    21'd2048,    32'd1046528}},
			'{OP_RELEASE, 32'd0,          48'd2048, 1'b1, '{STS_DONE,     48'd0,    21'd0,       32'd1048576}},
			'{OP_ALLOC,   32'd1048576,    48'd0,    1'b1, '{STS_DONE,     48'd0,    21'd1048576, 32'd0}},
			'{OP_ALLOC,   32'd1,          48'd0,    1'b1, '{STS_FAIL,     48'd0,    21'd1048576, 32'd0}},
			'{OP_RELEASE, 32'd0,          48'd0,    1'b1, '{STS_DONE,     48'd0,    21'd0,       32'd1048576}},
			'{OP_ALLOC,   32'd5000,       48'd0,    1'b0, '0},
			'{OP_ALLOC,   32'd70000,      48'd0,    1'b0, '0},
			'{OP_RELEASE, 32'd0,          48'd0,    1'b0, '0},
			'{OP_ALLOC,   32'd4096,       48'd0,    1'b0, '0},
			'{OP_RELEASE, 32'd0,          48'd5120, 1'b0, '0}
		};

		// pool settings per random phase, extremes included
		phase_base[0]  = 48'h0000_1000_0000; phase_total[0] = 32'd1048576;
		phase_base[1]  = 48'hFFFF_FFFF_FFFF; phase_total[1] = 32'd0;
		phase_base[2]  = {16'($urandom), 32'($urandom)};
		phase_total[2] = 32'hFFFF_FFFF;
		phase_base[3]  = 48'd0;              phase_total[3] = 32'd20000;
		phase_base[4]  = 48'hFFFF_FFFF_8000; phase_total[4] = $urandom;
		phase_base[5]  = BASE_RESET;         phase_total[5] = TOTAL_RESET;

		// reset
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int r = 0; r < PLAN_ROWS; r++)
			send_request(plan[r].op, plan[r].nbytes, plan[r].rel_addr, 1'b0,
				plan[r].typed, plan[r].want);

		// random phases: receiver-heavy idling, then sender-heavy, then none
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			set_pool(phase_base[p], phase_total[p]);
			snd_idle_pct = (p < 2) ? 35 : (p < 4) ? 73 : 0;
			rcv_idle_pct = (p < 2) ? 73 : (p < 4) ? 35 : 0;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				pick_request(op, nbytes, rel_addr);
				send_request(op, nbytes, rel_addr, k == 40, 1'b0, '0);
			end
		end

		// wait out the last results, then give stray output time to show up
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_cnt == 0 && replies_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
